// ----- hdl/obct_pkg.sv -----
`default_nettype none
package obct_pkg;

   localparam int TRIG_FRAC_BITS = 15;
   localparam int TW             = TRIG_FRAC_BITS + 1;
   localparam int ANG_W          = 16;
   localparam int CFG_W          = 16;
   localparam int LOC_W          = CFG_W + 2;
   localparam int COORD_W        = LOC_W + 2;
   localparam int WORLD_W        = 24;
   localparam int CORNER_COUNT   = 8;
   localparam int IDX_W          = $clog2(CORNER_COUNT);
   localparam int CSR_IDX_W      = 3;
   localparam int HORNER_STEPS   = 5;
   localparam int TRIG_LAT       = 7 + 2 * HORNER_STEPS;

   localparam logic [CSR_IDX_W-1:0] REG_HALF_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WIDTH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_HEIGHT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_OFFSET_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_OFFSET_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_OFFSET_Z = 3'd5;

   localparam logic [29:0] PI_APPROX_Q28 = 30'd843314144;
   localparam logic [29:0] PI_TRUE_Q28   = 30'd843314857;
   localparam logic [29:0] HALF_PI_Q28   = 30'd421657428;
   localparam logic [45:0] ANGLE_BIAS    = 46'd16382;
   localparam logic [43:0] DIV_8191      = 44'd8191;
   localparam logic [28:0] Q28_ONE       = 29'h1000_0000;

   localparam logic [63:0] ONE64 = 64'd1;
   localparam logic [30:0] SIN_RECIP [HORNER_STEPS] = '{
      31'(((ONE64 << 37) / 64'd110) + 64'd1),
      31'(((ONE64 << 37) / 64'd72) + 64'd1),
      31'(((ONE64 << 36) / 64'd42) + 64'd1),
      31'(((ONE64 << 35) / 64'd20) + 64'd1),
      31'(((ONE64 << 33) / 64'd6) + 64'd1)};
   localparam int SIN_SHIFT [HORNER_STEPS] = '{37, 37, 36, 35, 33};
   localparam logic [30:0] COS_RECIP [HORNER_STEPS] = '{
      31'(((ONE64 << 38) / 64'd132) + 64'd1),
      31'(((ONE64 << 37) / 64'd90) + 64'd1),
      31'(((ONE64 << 36) / 64'd56) + 64'd1),
      31'(((ONE64 << 35) / 64'd30) + 64'd1),
      31'(((ONE64 << 34) / 64'd12) + 64'd1)};
   localparam int COS_SHIFT [HORNER_STEPS] = '{38, 37, 36, 35, 34};

   typedef struct packed {
      logic signed [ANG_W-1:0]   car_pitch;
      logic signed [ANG_W-1:0]   car_yaw;
      logic signed [ANG_W-1:0]   car_roll;
      logic signed [WORLD_W-1:0] world_x;
      logic signed [WORLD_W-1:0] world_y;
      logic signed [WORLD_W-1:0] world_z;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          corner_index;
      logic signed [WORLD_W-1:0] corner_x;
      logic signed [WORLD_W-1:0] corner_y;
      logic signed [WORLD_W-1:0] corner_z;
      logic                      last_corner;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]        half_length;
      logic [CFG_W-1:0]        half_width;
      logic [CFG_W-1:0]        half_height;
      logic signed [CFG_W-1:0] center_offset_x;
      logic signed [CFG_W-1:0] center_offset_y;
      logic signed [CFG_W-1:0] center_offset_z;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic signed [TW-1:0] sin_v;
      logic signed [TW-1:0] cos_v;
   } trig_type;

   typedef struct packed {
      logic signed [WORLD_W-1:0] x;
      logic signed [WORLD_W-1:0] y;
      logic signed [WORLD_W-1:0] z;
   } world_type;

endpackage
`default_nettype wire

// ----- hdl/oriented_box_corner_transform_top.sv -----
// Oriented box corner transform. A pose is taken when start is high and busy
// is low; it yields eight corner items on rsp_valid/rsp_item in consecutive
// cycles, corner 0 first, last_corner set on corner 7. The receiver cannot
// stall: each item is shown for one cycle only. Poses overlap in the pipeline,
// but a down-counter holds busy high after each start so that corner runs do
// not collide; the corner sequencer emits one corner per cycle.
// The path to the first corner is the input register, which loads on the
// accepting edge, then 17 stages of the sine/cosine pipeline and 6 stages of
// corner rotation and output. Configuration writes take effect on the next
// cycle and are to be made only while no pose is in flight.
`default_nettype none
module oriented_box_corner_transform_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  obct_pkg::req_type                      req_item,
   output logic                                   rsp_valid,
   output obct_pkg::rsp_type                      rsp_item,
   input  wire logic                              csr_write_en,
   input  wire logic [obct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [obct_pkg::CFG_W-1:0]        csr_wdata
);

   obct_pkg::cfg_type          cfg_ff;
   logic [obct_pkg::IDX_W-1:0] busy_cnt_ff;
   logic                       accept;
   logic                       item_v_ff;
   obct_pkg::req_type          item_ff;
   obct_pkg::world_type        world_dly_ff [obct_pkg::TRIG_LAT];
   obct_pkg::trig_type         pitch_trig, yaw_trig, roll_trig;
   logic                       trig_valid;

   assign accept = start && !busy;
   assign busy   = (busy_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            obct_pkg::REG_HALF_LENGTH:     cfg_ff.half_length     <= csr_wdata;
            obct_pkg::REG_HALF_WIDTH:      cfg_ff.half_width      <= csr_wdata;
            obct_pkg::REG_HALF_HEIGHT:     cfg_ff.half_height     <= csr_wdata;
            obct_pkg::REG_CENTER_OFFSET_X: cfg_ff.center_offset_x <= csr_wdata;
            obct_pkg::REG_CENTER_OFFSET_Y: cfg_ff.center_offset_y <= csr_wdata;
            obct_pkg::REG_CENTER_OFFSET_Z: cfg_ff.center_offset_z <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cnt_ff <= '0;
         item_v_ff   <= 1'b0;
      end else begin
         item_v_ff <= accept;
         if (accept) begin
            busy_cnt_ff <= obct_pkg::IDX_W'(obct_pkg::CORNER_COUNT - 1);
         end else if (busy) begin
            busy_cnt_ff <= busy_cnt_ff - obct_pkg::IDX_W'(1);
         end
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      world_dly_ff[0].x <= item_ff.world_x;
      world_dly_ff[0].y <= item_ff.world_y;
      world_dly_ff[0].z <= item_ff.world_z;
      for (int i = 1; i < obct_pkg::TRIG_LAT; i++) begin
         world_dly_ff[i] <= world_dly_ff[i-1];
      end
   end

   obct_trig u_trig_pitch (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_v_ff),
      .angle    (item_ff.car_pitch),
      .trig_out (pitch_trig)
   );

   obct_trig u_trig_yaw (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_v_ff),
      .angle    (item_ff.car_yaw),
      .trig_out (yaw_trig)
   );

   obct_trig u_trig_roll (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_v_ff),
      .angle    (item_ff.car_roll),
      .trig_out (roll_trig)
   );

   assign trig_valid = pitch_trig.valid && yaw_trig.valid && roll_trig.valid;

   obct_corner u_corner (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .trig_valid (trig_valid),
      .pitch      (pitch_trig),
      .yaw        (yaw_trig),
      .roll       (roll_trig),
      .world      (world_dly_ff[obct_pkg::TRIG_LAT-1]),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire

// ----- hdl/obct_trig.sv -----
`default_nettype none
module obct_trig (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic signed [obct_pkg::ANG_W-1:0]    angle,
   output obct_pkg::trig_type                        trig_out
);

   typedef struct packed {
      logic        valid;
      logic        sneg;
      logic        cneg;
      logic [28:0] x;
      logic [29:0] x2;
   } hctl_type;

   function automatic logic signed [obct_pkg::TW-1:0] to_trig(logic [28:0] v, logic neg);
      logic [29:0]             sum;
      logic [29:0]             qv;
      logic [obct_pkg::TW-1:0] mag;
      sum = {1'b0, v} + (30'd1 << (27 - obct_pkg::TRIG_FRAC_BITS));
      qv  = sum >> (28 - obct_pkg::TRIG_FRAC_BITS);
      if (qv > 30'((1 << obct_pkg::TRIG_FRAC_BITS) - 1)) begin
         qv = 30'((1 << obct_pkg::TRIG_FRAC_BITS) - 1);
      end
      mag = qv[obct_pkg::TW-1:0];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // angle to radians, Q28
   logic [15:0] mag;
   logic [45:0] n_in;
   logic        s1_v_ff, s1_neg_ff;
   logic [45:0] s1_n_ff;

   assign mag  = angle[15] ? 16'(-angle) : angle;
   assign n_in = {30'd0, mag} * {16'd0, obct_pkg::PI_APPROX_Q28} + obct_pkg::ANGLE_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
      end
      s1_n_ff   <= n_in;
      s1_neg_ff <= angle[15];
   end

   // divide by 32764: quotient estimate by 8191 series
   logic [43:0] n4, s_sum;
   logic        s2_v_ff, s2_neg_ff;
   logic [43:0] s2_n4_ff;
   logic [29:0] s2_q0_ff;

   assign n4    = s1_n_ff[45:2];
   assign s_sum = n4 + (n4 >> 13) + (n4 >> 26) + (n4 >> 39);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_n4_ff  <= n4;
      s2_q0_ff  <= s_sum[42:13];
      s2_neg_ff <= s1_neg_ff;
   end

   // quotient correction
   logic [43:0] q_mul, rem;
   logic [29:0] th_in;
   logic        s3_v_ff, s3_neg_ff;
   logic [29:0] s3_th_ff;

   assign q_mul = ({14'd0, s2_q0_ff} << 13) - {14'd0, s2_q0_ff};
   assign rem   = s2_n4_ff - q_mul;
   assign th_in = (rem >= obct_pkg::DIV_8191) ? s2_q0_ff + 30'd1 : s2_q0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_th_ff  <= th_in;
      s3_neg_ff <= s2_neg_ff;
   end

   // fold into first quadrant
   logic [29:0] x_in;
   logic        sneg_in, cneg_in;
   logic        s4_v_ff, s4_sneg_ff, s4_cneg_ff;
   logic [28:0] s4_x_ff;

   always_comb begin
      sneg_in = s3_neg_ff;
      cneg_in = 1'b0;
      x_in    = s3_th_ff;
      if (s3_th_ff > obct_pkg::HALF_PI_Q28) begin
         cneg_in = 1'b1;
         if (s3_th_ff > obct_pkg::PI_TRUE_Q28) begin
            x_in    = s3_th_ff - obct_pkg::PI_TRUE_Q28;
            sneg_in = !s3_neg_ff;
         end else begin
            x_in = obct_pkg::PI_TRUE_Q28 - s3_th_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= s3_v_ff;
      end
      s4_x_ff    <= x_in[28:0];
      s4_sneg_ff <= sneg_in;
      s4_cneg_ff <= cneg_in;
   end

   // x squared
   logic [57:0] xx;
   hctl_type    s5_ctl_ff;

   assign xx = {29'd0, s4_x_ff} * {29'd0, s4_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff.valid <= 1'b0;
      end else begin
         s5_ctl_ff.valid <= s4_v_ff;
      end
      s5_ctl_ff.sneg <= s4_sneg_ff;
      s5_ctl_ff.cneg <= s4_cneg_ff;
      s5_ctl_ff.x    <= s4_x_ff;
      s5_ctl_ff.x2   <= xx[57:28];
   end

   // Horner steps: product stage, then reciprocal-multiply stage
   logic [29:0] ha_ps_ff  [obct_pkg::HORNER_STEPS];
   logic [29:0] ha_pc_ff  [obct_pkg::HORNER_STEPS];
   hctl_type    ha_ctl_ff [obct_pkg::HORNER_STEPS];
   logic [28:0] hb_ts_ff  [obct_pkg::HORNER_STEPS];
   logic [28:0] hb_tc_ff  [obct_pkg::HORNER_STEPS];
   hctl_type    hb_ctl_ff [obct_pkg::HORNER_STEPS];

   for (genvar j = 0; j < obct_pkg::HORNER_STEPS; j++) begin : g_horner
      logic [28:0] ts_cur, tc_cur;
      hctl_type    ctl_cur;
      logic [58:0] ps_full, pc_full;
      logic [60:0] qs_full, qc_full;

      if (j == 0) begin : g_first
         assign ts_cur  = obct_pkg::Q28_ONE;
         assign tc_cur  = obct_pkg::Q28_ONE;
         assign ctl_cur = s5_ctl_ff;
      end else begin : g_next
         assign ts_cur  = hb_ts_ff[j-1];
         assign tc_cur  = hb_tc_ff[j-1];
         assign ctl_cur = hb_ctl_ff[j-1];
      end

      assign ps_full = {29'd0, ctl_cur.x2} * {30'd0, ts_cur};
      assign pc_full = {29'd0, ctl_cur.x2} * {30'd0, tc_cur};
      assign qs_full = {31'd0, ha_ps_ff[j]} * {30'd0, obct_pkg::SIN_RECIP[j]};
      assign qc_full = {31'd0, ha_pc_ff[j]} * {30'd0, obct_pkg::COS_RECIP[j]};

      always_ff @(posedge clock) begin
         if (reset) begin
            ha_ctl_ff[j].valid <= 1'b0;
            hb_ctl_ff[j].valid <= 1'b0;
         end else begin
            ha_ctl_ff[j].valid <= ctl_cur.valid;
            hb_ctl_ff[j].valid <= ha_ctl_ff[j].valid;
         end
         ha_ctl_ff[j].sneg <= ctl_cur.sneg;
         ha_ctl_ff[j].cneg <= ctl_cur.cneg;
         ha_ctl_ff[j].x    <= ctl_cur.x;
         ha_ctl_ff[j].x2   <= ctl_cur.x2;
         ha_ps_ff[j]       <= ps_full[57:28];
         ha_pc_ff[j]       <= pc_full[57:28];
         hb_ctl_ff[j].sneg <= ha_ctl_ff[j].sneg;
         hb_ctl_ff[j].cneg <= ha_ctl_ff[j].cneg;
         hb_ctl_ff[j].x    <= ha_ctl_ff[j].x;
         hb_ctl_ff[j].x2   <= ha_ctl_ff[j].x2;
         hb_ts_ff[j] <= obct_pkg::Q28_ONE - 29'(qs_full >> obct_pkg::SIN_SHIFT[j]);
         hb_tc_ff[j] <= obct_pkg::Q28_ONE - 29'(qc_full >> obct_pkg::COS_SHIFT[j]);
      end
   end

   // final products
   hctl_type    last_ctl;
   logic [57:0] sv_full;
   logic [58:0] pcos_full;
   logic        s16_v_ff, s16_sneg_ff, s16_cneg_ff;
   logic [28:0] s16_sv_ff, s16_pc_ff;

   assign last_ctl  = hb_ctl_ff[obct_pkg::HORNER_STEPS-1];
   assign sv_full   = {29'd0, last_ctl.x} * {29'd0, hb_ts_ff[obct_pkg::HORNER_STEPS-1]};
   assign pcos_full = {29'd0, last_ctl.x2} * {30'd0, hb_tc_ff[obct_pkg::HORNER_STEPS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s16_v_ff <= 1'b0;
      end else begin
         s16_v_ff <= last_ctl.valid;
      end
      s16_sneg_ff <= last_ctl.sneg;
      s16_cneg_ff <= last_ctl.cneg;
      s16_sv_ff   <= sv_full[56:28];
      s16_pc_ff   <= pcos_full[57:29];
   end

   // round to output format, apply signs
   logic [28:0] cv;

   assign cv = (s16_pc_ff > obct_pkg::Q28_ONE) ? 29'd0 : obct_pkg::Q28_ONE - s16_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_out.valid <= 1'b0;
      end else begin
         trig_out.valid <= s16_v_ff;
      end
      trig_out.sin_v <= to_trig(s16_sv_ff, s16_sneg_ff);
      trig_out.cos_v <= to_trig(cv, s16_cneg_ff);
   end

endmodule
`default_nettype wire

// ----- hdl/obct_corner.sv -----
`default_nettype none
module obct_corner (
   input  wire logic                clock,
   input  wire logic                reset,
   input  obct_pkg::cfg_type        cfg,
   input  wire logic                trig_valid,
   input  obct_pkg::trig_type       pitch,
   input  obct_pkg::trig_type       yaw,
   input  obct_pkg::trig_type       roll,
   input  obct_pkg::world_type      world,
   output logic                     rsp_valid,
   output obct_pkg::rsp_type        rsp_item
);

   typedef struct packed {
      logic signed [obct_pkg::TW-1:0] sp;
      logic signed [obct_pkg::TW-1:0] cp;
      logic signed [obct_pkg::TW-1:0] sy;
      logic signed [obct_pkg::TW-1:0] cy;
      logic signed [obct_pkg::TW-1:0] sr;
      logic signed [obct_pkg::TW-1:0] cr;
      obct_pkg::world_type            world;
   } rot_type;

   typedef struct packed {
      logic                       valid;
      logic [obct_pkg::IDX_W-1:0] idx;
      logic                       last;
   } tag_type;

   localparam int PW = obct_pkg::COORD_W + obct_pkg::TW;

   function automatic logic signed [obct_pkg::COORD_W-1:0] rnd_mac(
      logic signed [obct_pkg::COORD_W-1:0] a, logic signed [obct_pkg::TW-1:0] ca,
      logic signed [obct_pkg::COORD_W-1:0] b, logic signed [obct_pkg::TW-1:0] cb);
      logic signed [PW-1:0] pa, pb;
      logic signed [PW:0]   acc;
      pa  = a * ca;
      pb  = b * cb;
      acc = (PW+1)'(pa) + (PW+1)'(pb) + (PW+1)'(1 << (obct_pkg::TRIG_FRAC_BITS - 1));
      return obct_pkg::COORD_W'(acc >>> obct_pkg::TRIG_FRAC_BITS);
   endfunction

   function automatic logic signed [obct_pkg::WORLD_W-1:0] sat_add(
      logic signed [obct_pkg::COORD_W-1:0] c, logic signed [obct_pkg::WORLD_W-1:0] w);
      logic signed [obct_pkg::WORLD_W:0] s;
      s = (obct_pkg::WORLD_W+1)'(c) + (obct_pkg::WORLD_W+1)'(w);
      if (s[obct_pkg::WORLD_W] != s[obct_pkg::WORLD_W-1]) begin
         return s[obct_pkg::WORLD_W] ? {1'b1, {(obct_pkg::WORLD_W-1){1'b0}}}
                                     : {1'b0, {(obct_pkg::WORLD_W-1){1'b1}}};
      end
      return s[obct_pkg::WORLD_W-1:0];
   endfunction

   // corner sequencer: holds one pose while it steps through the eight corners
   logic                       sq_active_ff;
   logic [obct_pkg::IDX_W-1:0] sq_k_ff;
   rot_type                    sq_rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_active_ff <= 1'b0;
         sq_k_ff      <= '0;
      end else if (trig_valid) begin
         sq_active_ff <= 1'b1;
         sq_k_ff      <= '0;
      end else if (sq_active_ff) begin
         if (sq_k_ff == obct_pkg::IDX_W'(obct_pkg::CORNER_COUNT - 1)) begin
            sq_active_ff <= 1'b0;
         end
         sq_k_ff <= sq_k_ff + obct_pkg::IDX_W'(1);
      end
      if (trig_valid) begin
         sq_rot_ff.sp    <= pitch.sin_v;
         sq_rot_ff.cp    <= pitch.cos_v;
         sq_rot_ff.sy    <= -yaw.sin_v;
         sq_rot_ff.cy    <= yaw.cos_v;
         sq_rot_ff.sr    <= roll.sin_v;
         sq_rot_ff.cr    <= roll.cos_v;
         sq_rot_ff.world <= world;
      end
   end

   // local corner
   logic signed [obct_pkg::LOC_W-1:0] hl, hw, hh;
   logic signed [obct_pkg::LOC_W-1:0] lx_in, ly_in, lz_in;
   tag_type                            g_tag_ff;
   rot_type                            g_rot_ff;
   logic signed [obct_pkg::LOC_W-1:0] g_x_ff, g_y_ff, g_z_ff;

   assign hl    = $signed({2'b00, cfg.half_length});
   assign hw    = $signed({2'b00, cfg.half_width});
   assign hh    = $signed({2'b00, cfg.half_height});
   assign lx_in = (sq_k_ff[1] ? -hl : hl) + obct_pkg::LOC_W'(cfg.center_offset_x);
   assign ly_in = (sq_k_ff[2] ? -hh : hh) + obct_pkg::LOC_W'(cfg.center_offset_z);
   assign lz_in = ((sq_k_ff[0] ^ sq_k_ff[1]) ? -hw : hw)
                  + obct_pkg::LOC_W'(cfg.center_offset_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_tag_ff.valid <= 1'b0;
      end else begin
         g_tag_ff.valid <= sq_active_ff;
      end
      g_tag_ff.idx  <= sq_k_ff;
      g_tag_ff.last <= (sq_k_ff == obct_pkg::IDX_W'(obct_pkg::CORNER_COUNT - 1));
      g_rot_ff      <= sq_rot_ff;
      g_x_ff        <= lx_in;
      g_y_ff        <= ly_in;
      g_z_ff        <= lz_in;
   end

   // roll
   logic signed [obct_pkg::COORD_W-1:0] gx, gy, gz;
   tag_type                              r1_tag_ff;
   rot_type                              r1_rot_ff;
   logic signed [obct_pkg::COORD_W-1:0] r1_x_ff, r1_y_ff, r1_z_ff;

   assign gx = obct_pkg::COORD_W'(g_x_ff);
   assign gy = obct_pkg::COORD_W'(g_y_ff);
   assign gz = obct_pkg::COORD_W'(g_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_tag_ff.valid <= 1'b0;
      end else begin
         r1_tag_ff.valid <= g_tag_ff.valid;
      end
      r1_tag_ff.idx  <= g_tag_ff.idx;
      r1_tag_ff.last <= g_tag_ff.last;
      r1_rot_ff      <= g_rot_ff;
      r1_x_ff        <= gx;
      r1_y_ff        <= rnd_mac(gy, g_rot_ff.cr, gz, -g_rot_ff.sr);
      r1_z_ff        <= rnd_mac(gy, g_rot_ff.sr, gz, g_rot_ff.cr);
   end

   // pitch
   tag_type                              r2_tag_ff;
   rot_type                              r2_rot_ff;
   logic signed [obct_pkg::COORD_W-1:0] r2_x_ff, r2_y_ff, r2_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_tag_ff.valid <= 1'b0;
      end else begin
         r2_tag_ff.valid <= r1_tag_ff.valid;
      end
      r2_tag_ff.idx  <= r1_tag_ff.idx;
      r2_tag_ff.last <= r1_tag_ff.last;
      r2_rot_ff      <= r1_rot_ff;
      r2_x_ff        <= rnd_mac(r1_x_ff, r1_rot_ff.cp, r1_y_ff, -r1_rot_ff.sp);
      r2_y_ff        <= rnd_mac(r1_x_ff, r1_rot_ff.sp, r1_y_ff, r1_rot_ff.cp);
      r2_z_ff        <= r1_z_ff;
   end

   // negated yaw
   tag_type                              r3_tag_ff;
   obct_pkg::world_type                  r3_world_ff;
   logic signed [obct_pkg::COORD_W-1:0] r3_x_ff, r3_y_ff, r3_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r3_tag_ff.valid <= 1'b0;
      end else begin
         r3_tag_ff.valid <= r2_tag_ff.valid;
      end
      r3_tag_ff.idx  <= r2_tag_ff.idx;
      r3_tag_ff.last <= r2_tag_ff.last;
      r3_world_ff    <= r2_rot_ff.world;
      r3_x_ff        <= rnd_mac(r2_x_ff, r2_rot_ff.cy, r2_z_ff, r2_rot_ff.sy);
      r3_z_ff        <= rnd_mac(r2_z_ff, r2_rot_ff.cy, r2_x_ff, -r2_rot_ff.sy);
      r3_y_ff        <= r2_y_ff;
   end

   // axis swap, world offset, saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= r3_tag_ff.valid;
      end
      rsp_item.corner_index <= r3_tag_ff.idx;
      rsp_item.last_corner  <= r3_tag_ff.last;
      rsp_item.corner_x     <= sat_add(r3_x_ff, r3_world_ff.x);
      rsp_item.corner_y     <= sat_add(r3_z_ff, r3_world_ff.y);
      rsp_item.corner_z     <= sat_add(r3_y_ff, r3_world_ff.z);
   end

endmodule
`default_nettype wire

// ----- hdl/obct_checker.sv -----
`default_nettype none
module obct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input obct_pkg::rsp_type rsp_item
);

   localparam logic [obct_pkg::IDX_W-1:0] LAST_IDX =
      obct_pkg::IDX_W'(obct_pkg::CORNER_COUNT - 1);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last_corner == (rsp_item.corner_index == LAST_IDX)))
      else $error("last_corner mismatch");

   a_corner_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.corner_index != LAST_IDX |=>
         rsp_valid && rsp_item.corner_index ==
            $past(rsp_item.corner_index) + obct_pkg::IDX_W'(1))
      else $error("corner run broken");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_item.corner_index == '0)
      else $error("run does not start at corner 0");

endmodule

bind oriented_box_corner_transform_top obct_checker u_obct_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
